// File: src/stq_pkg.sv
`timescale 1ns / 1ps

package stq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = 4;
    localparam int TIME_W      = 64;
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int RESQ_DEPTH  = 4;
    localparam int RESQ_PTR_W  = $clog2(RESQ_DEPTH);

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_CANCEL = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_QUERY  = 2'd3
    } req_type_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [SLOT_W-1:0] timer_id;
        logic [TIME_W-1:0] time_value;
    } in_t;

    typedef struct packed {
        logic [SLOT_W-1:0] fired_id;
        logic              fired;
        logic              was_pending;
        logic              last;
    } out_t;

    typedef struct packed {
        req_type_t         op;
        logic              slot_ok;
        logic [SLOT_W-1:0] timer_id;
        logic [TIME_W-1:0] time_value;
    } cmd_t;

    typedef struct packed {
        logic                   busy;
        logic [CNT_W-1:0]       queue_count;
        logic [TIMER_SLOTS-1:0] active;
    } eng_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INS_START,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_INSERT,
        ST_REPLY,
        ST_TICK_CHK,
        ST_TICK_RD,
        ST_TICK_CMP,
        ST_TICK_END
    } eng_state_t;

    // True when a is strictly later than b, comparing across wrap.
    function automatic logic is_after(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = b - a;
        return d[TIME_W-1];
    endfunction

endpackage

// File: src/sorted_timer_queue.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Word
// request   in         push / full        stq_pkg::in_t (req_type, timer_id, time_value)
// response  out        pop / empty        stq_pkg::out_t (fired_id, fired, was_pending, last)
//
// A request word passes through the request queue into the engine and then does its
// work: a query replies at once, a cancel removes its entry first, a start removes and
// then walks the expiry list of up to sixteen timers one entry at a time (read, then
// compare), and a tick removes expired timers one at a time. The single read port of the expiry store sets the walk.
// Reset clears the list count, the active marks and both queues; no clearing pass.
// A full response queue stalls the engine, and a busy engine fills the request queue.
module sorted_timer_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  stq_pkg::in_t  request,
    output logic          full,
    output logic          empty,
    input  logic          pop,
    output stq_pkg::out_t response
);

    // Front side: a short request queue that decodes each word.
    logic                 cmd_valid;
    logic                 cmd_take;
    stq_pkg::cmd_t        cmd;

    // Back side: the list engine and the response queue it feeds.
    logic                 res_full;
    logic                 res_push;
    stq_pkg::out_t        res_word;
    stq_pkg::eng_status_t status;

    stq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    stq_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_word  (res_word),
        .status    (status)
    );

    stq_result_q u_result_q
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_word (res_word),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .response (response)
    );

`ifndef SYNTHESIS
    // The engine never drops a word into a full response queue.
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("response word pushed into full queue");

    // The engine only takes a request that the front holds.
    assert property (@(posedge clk) disable iff (!rst_n) cmd_take |-> cmd_valid)
        else $error("request taken from empty front queue");

    // Between requests the list length matches the number of armed timers.
    assert property (@(posedge clk) disable iff (!rst_n)
        !status.busy |-> ($countones(status.active) == 32'(status.queue_count)))
        else $error("timer list length differs from active marks");

    // The list never grows past the number of slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.queue_count <= stq_pkg::CNT_W'(stq_pkg::TIMER_SLOTS))
        else $error("timer list overflow");
`endif

endmodule

// File: src/stq_front.sv
`timescale 1ns / 1ps

module stq_front
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  stq_pkg::in_t request,
    output logic         full,
    output logic         cmd_valid,
    output stq_pkg::cmd_t cmd,
    input  logic         cmd_take
);

    stq_pkg::cmd_t q_reg [stq_pkg::CMDQ_DEPTH];
    logic [stq_pkg::CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [stq_pkg::CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [stq_pkg::CMDQ_PTR_W:0]   cnt_reg;
    logic [stq_pkg::CMDQ_PTR_W-1:0] wr_ptr_next;
    logic [stq_pkg::CMDQ_PTR_W-1:0] rd_ptr_next;
    logic [stq_pkg::CMDQ_PTR_W:0]   cnt_next;
    logic                           do_wr;
    logic                           do_rd;
    stq_pkg::cmd_t                  decoded;

    // Decode the request and flag slot numbers beyond the table.
    always_comb
    begin
        decoded.op         = stq_pkg::req_type_t'(request.req_type);
        decoded.timer_id   = request.timer_id;
        decoded.time_value = request.time_value;
        decoded.slot_ok    = ({1'b0, request.timer_id} <
                              (stq_pkg::SLOT_W + 1)'(stq_pkg::TIMER_SLOTS));
    end

    assign full      = (cnt_reg == (stq_pkg::CMDQ_PTR_W + 1)'(stq_pkg::CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_wr     = push && !full;
    assign do_rd     = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (stq_pkg::CMDQ_PTR_W + 1)'(do_wr)
                              - (stq_pkg::CMDQ_PTR_W + 1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// File: src/stq_result_q.sv
`timescale 1ns / 1ps

module stq_result_q
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_push,
    input  stq_pkg::out_t res_word,
    output logic          res_full,
    output logic          empty,
    input  logic          pop,
    output stq_pkg::out_t response
);

    stq_pkg::out_t q_reg [stq_pkg::RESQ_DEPTH];
    logic [stq_pkg::RESQ_PTR_W-1:0] wr_ptr_reg;
    logic [stq_pkg::RESQ_PTR_W-1:0] rd_ptr_reg;
    logic [stq_pkg::RESQ_PTR_W:0]   cnt_reg;
    logic [stq_pkg::RESQ_PTR_W-1:0] wr_ptr_next;
    logic [stq_pkg::RESQ_PTR_W-1:0] rd_ptr_next;
    logic [stq_pkg::RESQ_PTR_W:0]   cnt_next;
    logic                           do_wr;
    logic                           do_rd;

    assign res_full = (cnt_reg == (stq_pkg::RESQ_PTR_W + 1)'(stq_pkg::RESQ_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign response = q_reg[rd_ptr_reg];
    assign do_wr    = res_push && !res_full;
    assign do_rd    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (stq_pkg::RESQ_PTR_W + 1)'(do_wr)
                              - (stq_pkg::RESQ_PTR_W + 1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wr_ptr_reg] <= res_word;
        end
    end

endmodule

// File: src/stq_engine.sv
`timescale 1ns / 1ps

module stq_engine
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  stq_pkg::cmd_t        cmd,
    output logic                 cmd_take,
    input  logic                 res_full,
    output logic                 res_push,
    output stq_pkg::out_t        res_word,
    output stq_pkg::eng_status_t status
);

    localparam int N = stq_pkg::TIMER_SLOTS;

    stq_pkg::eng_state_t state_reg, state_next;
    stq_pkg::cmd_t       cur_reg, cur_next;
    logic                pend_reg, pend_next;
    logic [stq_pkg::CNT_W-1:0]     pos_reg, pos_next;
    logic [stq_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [stq_pkg::SLOT_W-1:0]    order_reg [N];
    logic [stq_pkg::SLOT_W-1:0]    order_next [N];
    logic [N-1:0]                  active_reg, active_next;
    logic [stq_pkg::RES_CNT_W-1:0] n_reg, n_next;
    logic                          hold_valid_reg, hold_valid_next;
    logic [stq_pkg::SLOT_W-1:0]    hold_id_reg, hold_id_next;

    // Expiry store: one write port, one registered read port.
    logic [stq_pkg::TIME_W-1:0] exp_mem [N];
    logic [stq_pkg::TIME_W-1:0] rd_data_reg;
    logic                       mem_we;
    logic [stq_pkg::SLOT_W-1:0] rd_addr;

    logic                       rd_after_tv;
    logic                       tv_after_rd;
    logic [stq_pkg::CNT_W-1:0]  pos_inc;
    logic [stq_pkg::CNT_W-1:0]  rm_idx;
    logic                       rm_found;

    assign rd_addr     = order_reg[pos_reg[stq_pkg::SLOT_W-1:0]];
    assign rd_after_tv = stq_pkg::is_after(rd_data_reg, cur_reg.time_value);
    assign tv_after_rd = stq_pkg::is_after(cur_reg.time_value, rd_data_reg);
    assign pos_inc     = pos_reg + 1'b1;

    // Locate the list position of the timer being removed.
    always_comb
    begin
        rm_found = 1'b0;
        rm_idx   = '0;
        for (int i = 0; i < N; i++)
        begin
            if (!rm_found && (stq_pkg::CNT_W'(i) < count_reg) &&
                (order_reg[i] == cur_reg.timer_id))
            begin
                rm_found = 1'b1;
                rm_idx   = stq_pkg::CNT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == stq_pkg::REQ_TICK)
                        state_next = stq_pkg::ST_TICK_CHK;
                    else if (!cmd.slot_ok || cmd.op == stq_pkg::REQ_QUERY)
                        state_next = stq_pkg::ST_REPLY;
                    else
                        state_next = stq_pkg::ST_REMOVE;
                end
            end
            stq_pkg::ST_REMOVE:
            begin
                if (cur_reg.op == stq_pkg::REQ_START)
                    state_next = stq_pkg::ST_INS_START;
                else
                    state_next = stq_pkg::ST_REPLY;
            end
            stq_pkg::ST_INS_START:
            begin
                if (count_reg == stq_pkg::CNT_W'(N))
                    state_next = stq_pkg::ST_REPLY;
                else if (count_reg == '0)
                    state_next = stq_pkg::ST_INSERT;
                else
                    state_next = stq_pkg::ST_WALK_RD;
            end
            stq_pkg::ST_WALK_RD:
            begin
                state_next = stq_pkg::ST_WALK_CMP;
            end
            stq_pkg::ST_WALK_CMP:
            begin
                if (pos_reg == '0)
                begin
                    if (!rd_after_tv && (pos_inc < count_reg))
                        state_next = stq_pkg::ST_WALK_RD;
                    else
                        state_next = stq_pkg::ST_INSERT;
                end
                else if (tv_after_rd && (pos_inc < count_reg))
                    state_next = stq_pkg::ST_WALK_RD;
                else
                    state_next = stq_pkg::ST_INSERT;
            end
            stq_pkg::ST_INSERT:
            begin
                state_next = stq_pkg::ST_REPLY;
            end
            stq_pkg::ST_REPLY:
            begin
                if (!res_full)
                    state_next = stq_pkg::ST_IDLE;
            end
            stq_pkg::ST_TICK_CHK:
            begin
                if (n_reg == stq_pkg::RES_CNT_W'(stq_pkg::MAX_RESULTS) || count_reg == '0)
                    state_next = stq_pkg::ST_TICK_END;
                else
                    state_next = stq_pkg::ST_TICK_RD;
            end
            stq_pkg::ST_TICK_RD:
            begin
                state_next = stq_pkg::ST_TICK_CMP;
            end
            stq_pkg::ST_TICK_CMP:
            begin
                if (!tv_after_rd)
                    state_next = stq_pkg::ST_TICK_END;
                else if (!(hold_valid_reg && res_full))
                    state_next = stq_pkg::ST_TICK_CHK;
            end
            stq_pkg::ST_TICK_END:
            begin
                if (!res_full)
                    state_next = stq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = stq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_next        = cur_reg;
        pend_next       = pend_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        order_next      = order_reg;
        active_next     = active_reg;
        n_next          = n_reg;
        hold_valid_next = hold_valid_reg;
        hold_id_next    = hold_id_reg;
        cmd_take        = 1'b0;
        res_push        = 1'b0;
        res_word        = '0;
        mem_we          = 1'b0;
        case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take        = 1'b1;
                    cur_next        = cmd;
                    pend_next       = cmd.slot_ok && active_reg[cmd.timer_id];
                    pos_next        = '0;
                    n_next          = '0;
                    hold_valid_next = 1'b0;
                end
            end
            stq_pkg::ST_REMOVE:
            begin
                if (pend_reg && rm_found)
                begin
                    for (int i = 0; i < N - 1; i++)
                    begin
                        if (stq_pkg::CNT_W'(i) >= rm_idx)
                            order_next[i] = order_reg[i + 1];
                    end
                    count_next = count_reg - 1'b1;
                end
                active_next[cur_reg.timer_id] = 1'b0;
            end
            stq_pkg::ST_INS_START:
            begin
                mem_we   = (count_reg != stq_pkg::CNT_W'(N));
                pos_next = '0;
            end
            stq_pkg::ST_WALK_CMP:
            begin
                if (pos_reg == '0)
                begin
                    if (!rd_after_tv)
                        pos_next = pos_inc;
                end
                else if (tv_after_rd)
                    pos_next = pos_inc;
            end
            stq_pkg::ST_INSERT:
            begin
                for (int j = 0; j < N; j++)
                begin
                    if (stq_pkg::CNT_W'(j) == pos_reg)
                        order_next[j] = cur_reg.timer_id;
                    else if (j > 0 && stq_pkg::CNT_W'(j) > pos_reg)
                        order_next[j] = order_reg[(j > 0) ? j - 1 : 0];
                end
                count_next                    = count_reg + 1'b1;
                active_next[cur_reg.timer_id] = 1'b1;
            end
            stq_pkg::ST_REPLY:
            begin
                res_push             = !res_full;
                res_word.fired_id    = cur_reg.timer_id;
                res_word.fired       = 1'b0;
                res_word.was_pending = pend_reg;
                res_word.last        = 1'b1;
            end
            stq_pkg::ST_TICK_CMP:
            begin
                if (tv_after_rd && !(hold_valid_reg && res_full))
                begin
                    for (int i = 0; i < N - 1; i++)
                    begin
                        order_next[i] = order_reg[i + 1];
                    end
                    count_next               = count_reg - 1'b1;
                    active_next[order_reg[0]] = 1'b0;
                    res_push                 = hold_valid_reg;
                    res_word.fired_id        = hold_id_reg;
                    res_word.fired           = 1'b1;
                    res_word.was_pending     = 1'b0;
                    res_word.last            = 1'b0;
                    hold_valid_next          = 1'b1;
                    hold_id_next             = order_reg[0];
                    n_next                   = n_reg + 1'b1;
                end
            end
            stq_pkg::ST_TICK_END:
            begin
                res_push             = !res_full;
                res_word.fired_id    = hold_valid_reg ? hold_id_reg : cur_reg.timer_id;
                res_word.fired       = hold_valid_reg;
                res_word.was_pending = 1'b0;
                res_word.last        = 1'b1;
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    assign status.busy        = (state_reg != stq_pkg::ST_IDLE);
    assign status.queue_count = count_reg;
    assign status.active      = active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= stq_pkg::ST_IDLE;
            count_reg      <= '0;
            active_reg     <= '0;
            hold_valid_reg <= 1'b0;
            n_reg          <= '0;
            pos_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            active_reg     <= active_next;
            hold_valid_reg <= hold_valid_next;
            n_reg          <= n_next;
            pos_reg        <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        pend_reg    <= pend_next;
        order_reg   <= order_next;
        hold_id_reg <= hold_id_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            exp_mem[cur_reg.timer_id] <= cur_reg.time_value;
        end
        rd_data_reg <= exp_mem[rd_addr];
    end

endmodule
